// ===== design/irr_pkg.sv =====
`default_nettype none
package irr_pkg;

    localparam int MAX_FLOWS_DEF = 256;
    localparam int RATE_W        = 32;
    localparam int ITER_W        = 10;
    localparam int TOL_W         = 32;
    localparam int ACC_W         = 64;
    localparam int CFG_IDX_W     = 2;
    localparam int DIV_NW        = 94;  // |npv| << 30
    localparam int DIV_DW        = 64;

    localparam logic signed [RATE_W-1:0] START_RATE_RST = 32'sd107374182;
    localparam logic [ITER_W-1:0]        ITER_LIMIT_RST = 10'd100;
    localparam logic [TOL_W-1:0]         NPV_TOL_RST    = 32'd4295;

    localparam logic signed [RATE_W-1:0] Q30_ONE = 32'sh4000_0000;
    localparam logic signed [RATE_W-1:0] Q30_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [RATE_W-1:0] Q30_MIN = 32'sh8000_0000;
    localparam logic signed [ACC_W-1:0]  ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [ACC_W-1:0]  ACC_MIN = 64'sh8000_0000_0000_0000;

    typedef enum logic [1:0] {
        STAT_CONVERGED  = 2'd0,
        STAT_ZERO_SLOPE = 2'd1,
        STAT_LIMIT      = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_RATE = 2'd0,
        CFG_ITER_LIMIT = 2'd1,
        CFG_NPV_TOL    = 2'd2
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_LIM,
        ST_INV,
        ST_INV_WAIT,
        ST_RD,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_M4,
        ST_M5,
        ST_ACC,
        ST_EVAL,
        ST_STEP_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] dividend;
        logic [DIV_DW-1:0] divisor;
    } div_req_t;

    function automatic logic signed [ACC_W-1:0] sat_add64(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1])
        begin
            return s[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        return s[ACC_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== design/irr_newton_solver_unit.sv =====
`default_nettype none
// Internal rate of return solver. Cash flows are taken one per cycle into a
// flow memory of MAX_FLOWS entries (extra flows are dropped); the flow marked
// is_last closes the series and starts a Newton solve, during which no input
// is taken. Each iteration runs the limit check, the 1/(1+r) division
// (skipped when 1+r is zero), a memory read and the multiply/accumulate
// sequence for each stored flow, and, unless npv is within tolerance or the
// slope is zero, the npv/slope step division, both on the single divider.
// The result (rate Q2.30, status, iterations) sits in an output register, so
// loading of the next series starts while it waits to be taken.
module irr_newton_solver_unit #(
    parameter int MAX_FLOWS = irr_pkg::MAX_FLOWS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [irr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                   cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [31:0]            flow_value,
    input  wire logic                          is_last,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [31:0]                 found_rate,
    output logic [1:0]                         status,
    output logic [irr_pkg::ITER_W-1:0]         iterations_used
);

    localparam int CW = $clog2(MAX_FLOWS + 1);
    localparam int AW = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;
    localparam int KW = CW + 2;
    localparam int PW = 64 + KW;
    localparam int NW = irr_pkg::DIV_NW;

    // configuration
    logic signed [31:0]                start_rate_reg;
    logic [irr_pkg::ITER_W-1:0]        iter_limit_reg;
    logic [irr_pkg::TOL_W-1:0]         npv_tol_reg;

    irr_pkg::state_t                   state_reg, state_next;
    logic [CW-1:0]                     count_reg;
    logic [CW-1:0]                     idx_reg;
    logic [irr_pkg::ITER_W-1:0]        iter_reg;
    irr_pkg::status_t                  stat_reg;

    logic signed [31:0] rate_reg, dfac_reg, qinv_reg, next_reg, cf_reg;
    logic signed [63:0] p_dq_reg, p_cd_reg, p_cn_reg;
    logic signed [63:0] npv_reg, slope_reg, npv_term_reg, slope_term_reg;
    logic [31+KW-1:0]   hk_reg;
    logic [32+KW-1:0]   lk_reg;
    logic               tneg_reg;
    logic               dneg_reg;

    logic                              out_valid_reg;
    logic signed [31:0]                out_rate_reg;
    irr_pkg::status_t                  out_stat_reg;
    logic [irr_pkg::ITER_W-1:0]        out_iter_reg;

    irr_pkg::div_req_t                 div_req;
    logic                              div_done;
    logic [NW-1:0]                     div_quot;

    logic                              mem_wr_en;
    logic                              mem_rd_en;
    logic [31:0]                       mem_rdata;

    logic                              in_acc;
    logic                              out_load;

    // combinational datapath
    logic signed [32:0]  base;
    logic [32:0]         base_mag;
    logic signed [31:0]  inv_res;
    logic [63:0]         npv_mag, slope_mag;
    logic [32:0]         step_mag;
    logic signed [33:0]  step_s, rate_new;
    logic signed [31:0]  rate_clamped;
    logic [62:0]         dq_mag;
    logic [32:0]         dq_rnd;
    logic signed [33:0]  dq_s;
    logic signed [31:0]  next_val;
    logic signed [63:0]  npv_term;
    logic [62:0]         cn_mag;
    logic [KW-1:0]       kmul;
    logic [PW-1:0]       prod;
    logic signed [63:0]  slope_term;

    always_comb
    begin
        base     = {rate_reg[31], rate_reg} + 33'sh0_4000_0000;
        base_mag = base[32] ? 33'(-base) : 33'(base);

        if (!dneg_reg)
        begin
            inv_res = (div_quot > NW'(irr_pkg::Q30_MAX)) ? irr_pkg::Q30_MAX
                                                          : div_quot[31:0];
        end
        else
        begin
            inv_res = (div_quot > (NW'(1) << 31)) ? irr_pkg::Q30_MIN
                                                  : -div_quot[31:0];
        end

        npv_mag   = npv_reg[63] ? 64'(-npv_reg) : 64'(npv_reg);
        slope_mag = slope_reg[63] ? 64'(-slope_reg) : 64'(slope_reg);

        // step capped at 4.0
        step_mag = (div_quot >= (NW'(4) << 30)) ? 33'h1_0000_0000 : div_quot[32:0];
        step_s   = dneg_reg ? -{1'b0, step_mag} : {1'b0, step_mag};
        rate_new = {{2{rate_reg[31]}}, rate_reg} - step_s;
        if (rate_new > 34'sd2147483647)
        begin
            rate_clamped = irr_pkg::Q30_MAX;
        end
        else if (rate_new < -34'sd2147483648)
        begin
            rate_clamped = irr_pkg::Q30_MIN;
        end
        else
        begin
            rate_clamped = rate_new[31:0];
        end

        // next discount factor, round half away from zero
        dq_mag = p_dq_reg[63] ? 63'(-p_dq_reg) : p_dq_reg[62:0];
        dq_rnd = 33'((dq_mag + 63'(1 << 29)) >> 30);
        dq_s   = p_dq_reg[63] ? -{1'b0, dq_rnd} : {1'b0, dq_rnd};
        if (dq_s > 34'sd2147483647)
        begin
            next_val = irr_pkg::Q30_MAX;
        end
        else if (dq_s < -34'sd2147483648)
        begin
            next_val = irr_pkg::Q30_MIN;
        end
        else
        begin
            next_val = dq_s[31:0];
        end

        // cf*d scaled by 4 into Q32.32
        if (p_cd_reg > 64'sh1FFF_FFFF_FFFF_FFFF)
        begin
            npv_term = irr_pkg::ACC_MAX;
        end
        else if (p_cd_reg < -64'sh2000_0000_0000_0000)
        begin
            npv_term = irr_pkg::ACC_MIN;
        end
        else
        begin
            npv_term = p_cd_reg <<< 2;
        end

        cn_mag = p_cn_reg[63] ? 63'(-p_cn_reg) : p_cn_reg[62:0];
        kmul   = {idx_reg, 2'b00};

        prod = (PW'(hk_reg) << 32) + PW'(lk_reg);
        if (tneg_reg)
        begin
            slope_term = (prod > (PW'(1) << 63)) ? irr_pkg::ACC_MIN : -prod[63:0];
        end
        else
        begin
            slope_term = (prod > PW'(irr_pkg::ACC_MAX)) ? irr_pkg::ACC_MAX
                                                        : prod[63:0];
        end
    end

    assign in_acc   = in_valid && in_ready;
    assign out_load = (state_reg == irr_pkg::ST_DONE) && (!out_valid_reg || out_ready);
    assign mem_wr_en = in_acc && (count_reg < CW'(MAX_FLOWS));

    // control
    always_comb
    begin
        state_next      = state_reg;
        in_ready        = 1'b0;
        mem_rd_en       = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        case (state_reg)
            irr_pkg::ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid && is_last)
                begin
                    state_next = irr_pkg::ST_LIM;
                end
            end
            irr_pkg::ST_LIM:
            begin
                state_next = (iter_reg < iter_limit_reg) ? irr_pkg::ST_INV
                                                         : irr_pkg::ST_DONE;
            end
            irr_pkg::ST_INV:
            begin
                if (base == 33'sd0)
                begin
                    state_next = (count_reg == '0) ? irr_pkg::ST_EVAL : irr_pkg::ST_RD;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = (NW'(1) << 60) + NW'(base_mag >> 1);
                    div_req.divisor  = 64'(base_mag);
                    state_next       = irr_pkg::ST_INV_WAIT;
                end
            end
            irr_pkg::ST_INV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = (count_reg == '0) ? irr_pkg::ST_EVAL : irr_pkg::ST_RD;
                end
            end
            irr_pkg::ST_RD:
            begin
                mem_rd_en  = 1'b1;
                state_next = irr_pkg::ST_M1;
            end
            irr_pkg::ST_M1:  state_next = irr_pkg::ST_M2;
            irr_pkg::ST_M2:  state_next = irr_pkg::ST_M3;
            irr_pkg::ST_M3:  state_next = irr_pkg::ST_M4;
            irr_pkg::ST_M4:  state_next = irr_pkg::ST_M5;
            irr_pkg::ST_M5:  state_next = irr_pkg::ST_ACC;
            irr_pkg::ST_ACC:
            begin
                state_next = (idx_reg == count_reg - 1'b1) ? irr_pkg::ST_EVAL
                                                          : irr_pkg::ST_RD;
            end
            irr_pkg::ST_EVAL:
            begin
                if (npv_mag < 64'(npv_tol_reg) || slope_reg == 64'sd0)
                begin
                    state_next = irr_pkg::ST_DONE;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {npv_mag, 30'b0};
                    div_req.divisor  = slope_mag;
                    state_next       = irr_pkg::ST_STEP_WAIT;
                end
            end
            irr_pkg::ST_STEP_WAIT:
            begin
                if (div_done)
                begin
                    state_next = irr_pkg::ST_LIM;
                end
            end
            irr_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = irr_pkg::ST_LOAD;
                end
            end
            default: state_next = irr_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= irr_pkg::ST_LOAD;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            start_rate_reg <= irr_pkg::START_RATE_RST;
            iter_limit_reg <= irr_pkg::ITER_LIMIT_RST;
            npv_tol_reg    <= irr_pkg::NPV_TOL_RST;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    irr_pkg::CFG_START_RATE: start_rate_reg <= cfg_data;
                    irr_pkg::CFG_ITER_LIMIT: iter_limit_reg <= cfg_data[irr_pkg::ITER_W-1:0];
                    irr_pkg::CFG_NPV_TOL:    npv_tol_reg    <= cfg_data;
                    default: ;
                endcase
            end
            if (mem_wr_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (out_load)
            begin
                count_reg     <= '0;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            irr_pkg::ST_LOAD:
            begin
                if (in_acc && is_last)
                begin
                    rate_reg <= start_rate_reg;
                    iter_reg <= '0;
                    stat_reg <= irr_pkg::STAT_LIMIT;
                end
            end
            irr_pkg::ST_LIM:
            begin
                stat_reg <= irr_pkg::STAT_LIMIT;
            end
            irr_pkg::ST_INV:
            begin
                npv_reg   <= '0;
                slope_reg <= '0;
                dfac_reg  <= irr_pkg::Q30_ONE;
                idx_reg   <= '0;
                dneg_reg  <= base[32];
                qinv_reg  <= irr_pkg::Q30_MAX;
            end
            irr_pkg::ST_INV_WAIT:
            begin
                if (div_done)
                begin
                    qinv_reg <= inv_res;
                end
            end
            irr_pkg::ST_M1:
            begin
                cf_reg   <= $signed(mem_rdata);
                p_dq_reg <= dfac_reg * qinv_reg;
                p_cd_reg <= $signed(mem_rdata) * dfac_reg;
            end
            irr_pkg::ST_M2:
            begin
                next_reg     <= next_val;
                npv_term_reg <= npv_term;
            end
            irr_pkg::ST_M3:
            begin
                p_cn_reg <= cf_reg * next_reg;
                npv_reg  <= irr_pkg::sat_add64(npv_reg, npv_term_reg);
            end
            irr_pkg::ST_M4:
            begin
                hk_reg   <= (31+KW)'(cn_mag[62:32]) * (31+KW)'(kmul);
                lk_reg   <= (32+KW)'(cn_mag[31:0]) * (32+KW)'(kmul);
                tneg_reg <= !p_cn_reg[63] && (p_cn_reg != 64'sd0);
            end
            irr_pkg::ST_M5:
            begin
                slope_term_reg <= slope_term;
            end
            irr_pkg::ST_ACC:
            begin
                slope_reg <= irr_pkg::sat_add64(slope_reg, slope_term_reg);
                dfac_reg  <= next_reg;
                idx_reg   <= idx_reg + 1'b1;
            end
            irr_pkg::ST_EVAL:
            begin
                dneg_reg <= npv_reg[63] ^ slope_reg[63];
                if (npv_mag < 64'(npv_tol_reg))
                begin
                    stat_reg <= irr_pkg::STAT_CONVERGED;
                end
                else if (slope_reg == 64'sd0)
                begin
                    stat_reg <= irr_pkg::STAT_ZERO_SLOPE;
                end
            end
            irr_pkg::ST_STEP_WAIT:
            begin
                if (div_done)
                begin
                    rate_reg <= rate_clamped;
                    iter_reg <= iter_reg + 1'b1;
                end
            end
            default: ;
        endcase
        if (out_load)
        begin
            out_rate_reg <= rate_reg;
            out_stat_reg <= stat_reg;
            out_iter_reg <= iter_reg;
        end
    end

    irr_flow_mem #(
        .DEPTH (MAX_FLOWS),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (flow_value),
        .rd_en   (mem_rd_en),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (mem_rdata)
    );

    irr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign out_valid       = out_valid_reg;
    assign found_rate      = out_rate_reg;
    assign status          = out_stat_reg;
    assign iterations_used = out_iter_reg;

endmodule
`default_nettype wire

// ===== design/irr_flow_mem.sv =====
`default_nettype none
module irr_flow_mem #(
    parameter int DEPTH = irr_pkg::MAX_FLOWS_DEF,
    parameter int AW    = 8
) (
    input  wire logic                      clk,
    input  wire logic                      wr_en,
    input  wire logic [AW-1:0]             wr_addr,
    input  wire logic [irr_pkg::RATE_W-1:0] wr_data,
    input  wire logic                      rd_en,
    input  wire logic [AW-1:0]             rd_addr,
    output logic      [irr_pkg::RATE_W-1:0] rd_data
);

    logic [irr_pkg::RATE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== design/irr_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module irr_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire irr_pkg::div_req_t          req,
    output logic                            done,
    output logic [irr_pkg::DIV_NW-1:0]      quotient
);

    localparam int NW = irr_pkg::DIV_NW;
    localparam int DW = irr_pkg::DIV_DW;
    localparam int CNT_W = $clog2(NW);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DW:0]       rem_reg;
    logic [NW-1:0]     quo_reg;
    logic [DW-1:0]     dvs_reg;

    logic [DW:0]       rem_sh;
    logic [DW+1:0]     diff;
    logic              ge;

    always_comb
    begin
        rem_sh = {rem_reg[DW-1:0], quo_reg[NW-1]};
        diff   = {1'b0, rem_sh} - {2'b00, dvs_reg};
        ge     = ~diff[DW+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DW:0] : rem_sh;
            quo_reg <= {quo_reg[NW-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

// ===== design/irr_checker.sv =====
`default_nettype none
module irr_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          is_last,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic signed [31:0]            found_rate,
    input wire logic [1:0]                    status,
    input wire logic [irr_pkg::ITER_W-1:0]    iterations_used
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found_rate)
            && $stable(status) && $stable(iterations_used))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == irr_pkg::STAT_CONVERGED
            || status == irr_pkg::STAT_ZERO_SLOPE || status == irr_pkg::STAT_LIMIT)
        else $error("bad status code");

    // closing a series starts the solve, input blocked
    a_solve_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && is_last |=> !in_ready)
        else $error("input taken right after series close");

    // a new result never appears right after a plain flow load
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_valid && in_ready && !is_last))
        else $error("result without a solve");

endmodule

bind irr_newton_solver_unit irr_checker u_chk (.*);
`default_nettype wire

// ===== test/irr_newton_solver_unit_tb.sv =====
`timescale 1ns / 1ps

module irr_newton_solver_unit_tb;

    localparam longint ACC_HI = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint ACC_LO = 64'sh8000_0000_0000_0000;
    localparam longint RATE_HI = 64'sd2147483647;
    localparam longint RATE_LO = -64'sd2147483648;
    localparam longint ONE_Q30 = 64'sd1 << 30;
    localparam int STORE_DEPTH = irr_pkg::MAX_FLOWS_DEF;

    typedef struct {
        logic signed [31:0]         rate;
        irr_pkg::status_t           st;
        logic [irr_pkg::ITER_W-1:0] iters;
    } irr_result_t;

    class irr_scoreboard;
        longint            start_rate;
        int unsigned       iter_limit;
        longint unsigned   npv_tol;
        longint            flows[$];
        irr_result_t       pending_q[$];

        function new();
            start_rate = irr_pkg::START_RATE_RST;
            iter_limit = irr_pkg::ITER_LIMIT_RST;
            npv_tol    = irr_pkg::NPV_TOL_RST;
        endfunction

        function void set_reg(irr_pkg::cfg_idx_t idx, logic [31:0] v);
            case (idx)
                irr_pkg::CFG_START_RATE: start_rate = longint'(signed'(v));
                irr_pkg::CFG_ITER_LIMIT: iter_limit = v[irr_pkg::ITER_W-1:0];
                irr_pkg::CFG_NPV_TOL:    npv_tol = v;
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_q.size();
        endfunction

        static function longint unsigned mag(longint v);
            return v < 0 ? longint'(-v) : v;
        endfunction

        static function longint clamp_rate(longint v);
            return v > RATE_HI ? RATE_HI : (v < RATE_LO ? RATE_LO : v);
        endfunction

        static function longint mul_round(longint a, longint b);
            longint p;
            longint unsigned m;
            p = a * b;
            m = (mag(p) + (64'd1 << 29)) >> 30;
            return clamp_rate(p < 0 ? -longint'(m) : longint'(m));
        endfunction

        static function longint acc_add(longint a, longint b);
            longint s;
            s = a + b;
            if (a[63] == b[63] && s[63] != a[63])
                return a[63] ? ACC_LO : ACC_HI;
            return s;
        endfunction

        static function longint acc_scale(longint p, longint unsigned k);
            longint unsigned lim;
            if (k == 0)
                return 0;
            lim = 64'h7FFF_FFFF_FFFF_FFFF;
            if (p >= 0)
            begin
                if (longint'(p) > longint'(lim / k))
                    return ACC_HI;
            end
            else if (p < ACC_LO / longint'(k))
                return ACC_LO;
            return p * longint'(k);
        endfunction

        // 1/(1+r) in Q2.30
        static function longint discount_step(longint rate);
            longint base;
            longint unsigned m, q;
            base = ONE_Q30 + rate;
            if (base == 0)
                return RATE_HI;
            m = mag(base);
            q = ((64'd1 << 60) + m / 2) / m;
            if (base > 0)
                return q > 64'h7FFF_FFFF ? RATE_HI : longint'(q);
            return q > (64'd1 << 31) ? RATE_LO : -longint'(q);
        endfunction

        static function longint newton_delta(longint num, longint den);
            longint unsigned n, d, qi, rem, frac, q;
            n = mag(num);
            d = mag(den);
            qi = n / d;
            rem = n % d;
            frac = 0;
            if (qi >= 4)
                q = 64'd4 << 30;
            else
            begin
                for (int k = 0; k < 30; k++)
                begin
                    rem = rem << 1;
                    frac = frac << 1;
                    if (rem >= d)
                    begin
                        rem = rem - d;
                        frac = frac | 1;
                    end
                end
                q = (qi << 30) | frac;
            end
            return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
        endfunction

        function void note_flow(logic signed [31:0] v, logic last);
            irr_result_t r;
            longint rate, q, npv, slope, d, nxt, cf;
            int unsigned iters;
            irr_pkg::status_t st;
            if (flows.size() < STORE_DEPTH)
                flows.push_back(longint'(v));
            if (!last)
                return;
            rate = start_rate;
            iters = 0;
            st = irr_pkg::STAT_LIMIT;
            while (iters < iter_limit)
            begin
                q = discount_step(rate);
                npv = 0;
                slope = 0;
                d = ONE_Q30;
                foreach (flows[i])
                begin
                    cf = flows[i];
                    nxt = mul_round(d, q);
                    npv = acc_add(npv, acc_scale(cf * d, 4));
                    slope = acc_add(slope, acc_scale(-(cf * nxt), longint'(i) * 4));
                    d = nxt;
                end
                if (mag(npv) < npv_tol)
                begin
                    st = irr_pkg::STAT_CONVERGED;
                    break;
                end
                if (slope == 0)
                begin
                    st = irr_pkg::STAT_ZERO_SLOPE;
                    break;
                end
                rate = clamp_rate(rate - newton_delta(npv, slope));
                iters++;
            end
            flows.delete();
            r.rate = rate[31:0];
            r.st = st;
            r.iters = iters[irr_pkg::ITER_W-1:0];
            pending_q.push_back(r);
        endfunction

        // returns an empty string when the result matches
        function string check(logic signed [31:0] rate, logic [1:0] st,
                              logic [irr_pkg::ITER_W-1:0] iters);
            irr_result_t e;
            string msg;
            if (pending_q.size() == 0)
                return $sformatf("unexpected result rate=%0d status=%0d iters=%0d",
                                 rate, st, iters);
            e = pending_q.pop_front();
            msg = "";
            if (rate !== e.rate)
                msg = {msg, $sformatf(" found_rate %0d exp %0d", rate, e.rate)};
            if (st !== e.st)
                msg = {msg, $sformatf(" status %0d exp %0d", st, e.st)};
            if (iters !== e.iters)
                msg = {msg, $sformatf(" iterations_used %0d exp %0d", iters, e.iters)};
            return msg;
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_write;
    logic [irr_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [31:0]                   cfg_data;
    logic                          in_valid;
    logic                          in_ready;
    logic signed [31:0]            flow_value;
    logic                          is_last;
    logic                          out_valid;
    logic                          out_ready;
    logic signed [31:0]            found_rate;
    logic [1:0]                    status;
    logic [irr_pkg::ITER_W-1:0]    iterations_used;

    irr_scoreboard board;
    int errors;
    int snd_idle;
    int rcv_idle;
    bit hold_req;

    irr_newton_solver_unit u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .flow_value      (flow_value),
        .is_last         (is_last),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .found_rate      (found_rate),
        .status          (status),
        .iterations_used (iterations_used)
    );

    always #6 clk = ~clk;

    task automatic report(string msg);
        $display("MISMATCH @%0t:%s", $realtime, msg);
        errors++;
    endtask

    always @(posedge clk)
    begin
        string msg;
        if (rst_n && out_valid && out_ready)
        begin
            msg = board.check(found_rate, status, iterations_used);
            if (msg != "")
                report(msg);
        end
    end

    // receiver: random backpressure, or a long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 0;
                repeat (20000)
                begin
                    out_ready <= 1'b0;
                    @(posedge clk);
                end
            end
            out_ready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    initial
    begin
        #200_000_000;
        $display("irr_newton_solver_unit regression: fail");
        $finish;
    end

    task automatic write_reg(irr_pkg::cfg_idx_t idx, logic [31:0] v);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        board.set_reg(idx, v);
    endtask

    task automatic send_flow(logic signed [31:0] v, logic last);
        if ($urandom_range(99) < snd_idle)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < snd_idle);
        end
        in_valid   <= 1'b1;
        flow_value <= v;
        is_last    <= last;
        do @(posedge clk); while (!in_ready);
        board.note_flow(v, last);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // mostly an outlay followed by returns; otherwise arbitrary values
    task automatic send_series(output int len);
        bit formed;
        formed = ($urandom_range(99) < 70);
        len = formed ? $urandom_range(2, 7) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
        begin
            if (!formed)
                send_flow(rand_word(), i == len - 1);
            else if (i == 0)
                send_flow(-$signed($urandom_range(1, 1000000)), 1'b0);
            else
                send_flow($urandom_range(0, 400000), i == len - 1);
        end
    endtask

    initial
    begin
        int n;
        int sent;
        clk = 0;
        rst_n = 0;
        cfg_write = 0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 0;
        flow_value = '0;
        is_last = 0;
        out_ready = 0;
        errors = 0;
        snd_idle = 0;
        rcv_idle = 0;
        hold_req = 0;
        board = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        send_flow(-100, 1'b0);
        send_flow(110, 1'b1);
        send_flow(32'sh7FFF_FFFF, 1'b0);
        send_flow(32'sh8000_0000, 1'b1);
        send_flow(0, 1'b1);
        send_flow(5, 1'b1);                 // lone flow: zero slope
        drain();
        write_reg(irr_pkg::CFG_START_RATE, 32'hC000_0000);   // 1+r == 0
        send_flow(-100, 1'b0);
        send_flow(50, 1'b0);
        send_flow(60, 1'b1);
        drain();
        write_reg(irr_pkg::CFG_ITER_LIMIT, 0);
        send_flow(1, 1'b0);
        send_flow(2, 1'b1);
        drain();
        write_reg(irr_pkg::CFG_ITER_LIMIT, 1023);
        write_reg(irr_pkg::CFG_NPV_TOL, 32'hFFFF_FFFF);
        write_reg(irr_pkg::CFG_START_RATE, 32'h7FFF_FFFF);
        send_flow(-1, 1'b0);
        send_flow(1, 1'b1);
        drain();
        write_reg(irr_pkg::CFG_ITER_LIMIT, 5);
        write_reg(irr_pkg::CFG_NPV_TOL, 0);
        send_flow(-1000, 1'b0);
        send_flow(600, 1'b0);
        send_flow(600, 1'b1);
        drain();
        write_reg(irr_pkg::CFG_START_RATE, 32'h8000_0000);
        send_flow(-1000, 1'b0);
        send_flow(1200, 1'b1);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            snd_idle = (ph / 2 == 0) ? 38 : (ph / 2 == 1) ? 46 : 0;
            rcv_idle = (ph / 2 == 0) ? 46 : (ph / 2 == 1) ? 38 : 0;
            drain();
            case (ph)
                3: write_reg(irr_pkg::CFG_START_RATE, 32'h8000_0000);
                5: write_reg(irr_pkg::CFG_START_RATE, 32'h7FFF_FFFF);
                default: write_reg(irr_pkg::CFG_START_RATE,
                                   $urandom_range(0, 32'h4000_0000) - 32'h2000_0000);
            endcase
            write_reg(irr_pkg::CFG_ITER_LIMIT, ph == 2 ? 100 : $urandom_range(1, 12));
            case (ph)
                2: write_reg(irr_pkg::CFG_NPV_TOL, 4295);
                3: write_reg(irr_pkg::CFG_NPV_TOL, 0);
                5: write_reg(irr_pkg::CFG_NPV_TOL, 32'hFFFF_FFFF);
                default: write_reg(irr_pkg::CFG_NPV_TOL, $urandom);
            endcase
            if (ph == 1)
                hold_req = 1;
            if (ph == 4)
            begin
                // overfill the flow store; the marker still closes the series
                write_reg(irr_pkg::CFG_ITER_LIMIT, 2);
                for (int i = 0; i < 262; i++)
                    send_flow(rand_word(), i == 261);
            end
            sent = 0;
            while (sent < 90)
            begin
                send_series(n);
                sent += n;
                if (ph == 3 && sent >= 45 && sent - n < 45)
                begin
                    in_valid <= 1'b0;
                    while (board.pending() != 0)
                        @(posedge clk);
                end
            end
        end

        drain();
        repeat (500) @(posedge clk);
        if (errors == 0)
            $display("irr_newton_solver_unit regression: pass");
        else
            $display("irr_newton_solver_unit regression: fail");
        $finish;
    end

endmodule
